@@ rtl/bts_pkg.sv @@
// bts_pkg: shared constants, codes, types and the volume duty lookup
// for the buzzer tone sequencer. Depends on nothing.
package bts_pkg;

   localparam int STEP_DEPTH  = 16;
   localparam int STEP_IDX_W  = $clog2(STEP_DEPTH);
   localparam int STEP_CNT_W  = $clog2(STEP_DEPTH + 1);
   localparam int DUTY_BITS   = 10;
   localparam int DUTY_STRIDE = 10;
   localparam int VOL_CLAMP   = 4;

   localparam logic [9:0]  DUTY_MASK             = 10'((1 << DUTY_BITS) - 1);
   localparam logic [15:0] REMINDER_ON_RESET     = 16'd450;
   localparam logic [15:0] REMINDER_PERIOD_RESET = 16'd15000;

   // request modes
   localparam logic [2:0] MODE_TICK      = 3'd0;
   localparam logic [2:0] MODE_LOAD_STEP = 3'd1;
   localparam logic [2:0] MODE_START_SEQ = 3'd2;
   localparam logic [2:0] MODE_REM_START = 3'd3;
   localparam logic [2:0] MODE_REM_STOP  = 3'd4;

   // register indexes
   localparam logic [2:0] CSR_VOLUME     = 3'd0;
   localparam logic [2:0] CSR_DUTY_TABLE = 3'd1;
   localparam logic [2:0] CSR_REM_FREQ   = 3'd2;
   localparam logic [2:0] CSR_REM_ON     = 3'd3;
   localparam logic [2:0] CSR_REM_PERIOD = 3'd4;

   typedef struct packed {
      logic [15:0] freq;
      logic [15:0] on_ms;
      logic [15:0] gap_ms;
   } step_type;

   typedef struct packed {
      logic        en;
      logic [STEP_IDX_W-1:0] slot;
      step_type    data;
   } tbl_wr_type;

   typedef struct packed {
      logic [3:0]  volume_level;
      logic [49:0] duty_table;
      logic [15:0] reminder_freq_hz;
      logic [15:0] reminder_on_ms;
      logic [15:0] reminder_period_ms;
   } cfg_type;

   typedef struct packed {
      logic [2:0]  mode;
      logic [3:0]  step_slot;
      logic [15:0] step_freq_hz;
      logic [15:0] step_on_ms;
      logic [15:0] step_gap_ms;
      logic [7:0]  step_total;
   } req_item_type;

   typedef struct packed {
      logic [15:0] tone_freq_hz;
      logic [9:0]  tone_duty;
      logic        sequence_busy;
      logic        reminder_armed;
   } rsp_item_type;

   function automatic logic [9:0] volume_duty(input logic [3:0] vol,
                                              input logic [49:0] tbl);
      logic [2:0] v;
      v = (vol > 4'(VOL_CLAMP)) ? 3'(VOL_CLAMP) : vol[2:0];
      return tbl[DUTY_STRIDE*v +: 10] & DUTY_MASK;
   endfunction

endpackage

@@ rtl/bts_if.sv @@
// bts_if: valid/ready channel interfaces for requests, results and
// register writes. Depends on nothing; field widths are written out.
interface bts_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  mode;
   logic [3:0]  step_slot;
   logic [15:0] step_freq_hz;
   logic [15:0] step_on_ms;
   logic [15:0] step_gap_ms;
   logic [7:0]  step_total;

   modport source (output valid, mode, step_slot, step_freq_hz, step_on_ms,
                   step_gap_ms, step_total, input ready);
   modport sink (input valid, mode, step_slot, step_freq_hz, step_on_ms,
                 step_gap_ms, step_total, output ready);
endinterface

interface bts_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] tone_freq_hz;
   logic [9:0]  tone_duty;
   logic        sequence_busy;
   logic        reminder_armed;

   modport source (output valid, tone_freq_hz, tone_duty, sequence_busy,
                   reminder_armed, input ready);
   modport sink (input valid, tone_freq_hz, tone_duty, sequence_busy,
                 reminder_armed, output ready);
endinterface

interface bts_csr_if;
   logic        valid;
   logic        ready;
   logic [2:0]  index;
   logic [49:0] data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

@@ rtl/buzzer_tone_sequencer.sv @@
// buzzer_tone_sequencer: top level with request register, result register
// and configuration registers. Depends on bts_pkg, bts_if and bts_core.
// A request is held in the request register, and its result in the result register.
// Throughput: one request per cycle while results are taken, set by the single update pass in bts_core.
// Reset (synchronous, active high) clears control state and loads register
// defaults; the step table is not cleared and holds junk until loaded.
module buzzer_tone_sequencer (
   input logic       clock,
   input logic       reset,
   bts_req_if.sink   req_ch,
   bts_rsp_if.source rsp_ch,
   bts_csr_if.sink   csr_ch
);

   logic                  req_valid_ff;
   bts_pkg::req_item_type req_item_ff;
   logic                  rsp_valid_ff, rsp_valid_in;
   bts_pkg::rsp_item_type rsp_item_ff;
   bts_pkg::rsp_item_type core_result;
   bts_pkg::cfg_type      cfg_ff;
   logic                  go;

   // process the held request whenever the result register can take it
   assign go           = req_valid_ff && (!rsp_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !req_valid_ff || go;
   assign rsp_valid_in = go || (rsp_valid_ff && !rsp_ch.ready);
   assign csr_ch.ready = 1'b1;

   bts_core u_core (
      .clock  (clock),
      .reset  (reset),
      .go     (go),
      .req    (req_item_ff),
      .cfg    (cfg_ff),
      .result (core_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_ch.ready) begin
            req_valid_ff <= req_ch.valid;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ch.valid && req_ch.ready) begin
         req_item_ff <= '{mode: req_ch.mode, step_slot: req_ch.step_slot,
                          step_freq_hz: req_ch.step_freq_hz,
                          step_on_ms: req_ch.step_on_ms,
                          step_gap_ms: req_ch.step_gap_ms,
                          step_total: req_ch.step_total};
      end
      if (go) begin
         rsp_item_ff <= core_result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.volume_level       <= '0;
         cfg_ff.duty_table         <= '0;
         cfg_ff.reminder_freq_hz   <= '0;
         cfg_ff.reminder_on_ms     <= bts_pkg::REMINDER_ON_RESET;
         cfg_ff.reminder_period_ms <= bts_pkg::REMINDER_PERIOD_RESET;
      end else if (csr_ch.valid) begin
         case (csr_ch.index)
            bts_pkg::CSR_VOLUME:     cfg_ff.volume_level       <= csr_ch.data[3:0];
            bts_pkg::CSR_DUTY_TABLE: cfg_ff.duty_table         <= csr_ch.data;
            bts_pkg::CSR_REM_FREQ:   cfg_ff.reminder_freq_hz   <= csr_ch.data[15:0];
            bts_pkg::CSR_REM_ON:     cfg_ff.reminder_on_ms     <= csr_ch.data[15:0];
            bts_pkg::CSR_REM_PERIOD: cfg_ff.reminder_period_ms <= csr_ch.data[15:0];
            default: begin
            end
         endcase
      end
   end

   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.tone_freq_hz   = rsp_item_ff.tone_freq_hz;
   assign rsp_ch.tone_duty      = rsp_item_ff.tone_duty;
   assign rsp_ch.sequence_busy  = rsp_item_ff.sequence_busy;
   assign rsp_ch.reminder_armed = rsp_item_ff.reminder_armed;

endmodule

@@ rtl/bts_step_table.sv @@
// bts_step_table: flip-flop table of tone steps, one write port and one
// combinational read port. Depends on bts_pkg.
module bts_step_table (
   input  logic                          clock,
   input  bts_pkg::tbl_wr_type           wr,
   input  logic [bts_pkg::STEP_IDX_W-1:0] rd_idx,
   output bts_pkg::step_type             rd_data
);

   bts_pkg::step_type entry_ff [bts_pkg::STEP_DEPTH];

   always_ff @(posedge clock) begin
      if (wr.en) begin
         entry_ff[wr.slot] <= wr.data;
      end
   end

   assign rd_data = entry_ff[rd_idx];

endmodule

@@ rtl/bts_core.sv @@
// bts_core: sequencer and reminder state with the per-request update logic,
// plus the step table. Depends on bts_pkg and bts_step_table.
module bts_core (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  go,
   input  bts_pkg::req_item_type req,
   input  bts_pkg::cfg_type      cfg,
   output bts_pkg::rsp_item_type result
);

   localparam int CW = bts_pkg::STEP_CNT_W;

   logic [31:0]   clock_ms_ff, clock_ms_in;
   logic [31:0]   clock_nx_ff, clock_nx_in;   // always clock_ms + 1
   logic [CW-1:0] steps_ff, steps_in;
   logic [CW-1:0] cur_ff, cur_in;
   logic          tone_on_ff, tone_on_in;
   logic          in_gap_ff, in_gap_in;
   logic [31:0]   step_dl_ff, step_dl_in;
   logic          rem_en_ff, rem_en_in;
   logic          rem_snd_ff, rem_snd_in;
   logic [31:0]   rem_dl_ff, rem_dl_in;
   logic [15:0]   rem_gap_ff, rem_gap_in;
   logic [15:0]   bz_freq_ff, bz_freq_in;
   logic [9:0]    bz_duty_ff, bz_duty_in;

   bts_pkg::tbl_wr_type tbl_wr;
   bts_pkg::step_type   cur_step;
   logic [9:0]          vol_duty;
   logic [31:0]         seq_sum;
   logic [31:0]         rem_sum;
   logic                seq_due;
   logic                rem_due;
   logic                seq_start_tone;
   logic [CW-1:0]       cur_inc;
   logic [CW-1:0]       total_sat;

   bts_step_table u_table (
      .clock   (clock),
      .wr      (tbl_wr),
      .rd_idx  (cur_ff[bts_pkg::STEP_IDX_W-1:0]),
      .rd_data (cur_step)
   );

   assign vol_duty       = bts_pkg::volume_duty(cfg.volume_level, cfg.duty_table);
   assign seq_start_tone = !tone_on_ff && !in_gap_ff;
   // one adder for both step deadlines, one for both reminder deadlines
   assign seq_sum   = clock_nx_ff + (seq_start_tone ? 32'(cur_step.on_ms)
                                                    : 32'(cur_step.gap_ms));
   assign rem_sum   = clock_nx_ff + (rem_snd_ff ? 32'(rem_gap_ff)
                                                : 32'(cfg.reminder_on_ms));
   assign seq_due   = clock_nx_ff >= step_dl_ff;
   assign rem_due   = clock_nx_ff >= rem_dl_ff;
   assign cur_inc   = cur_ff + CW'(1);
   assign total_sat = (32'(req.step_total) > bts_pkg::STEP_DEPTH)
                      ? CW'(bts_pkg::STEP_DEPTH) : CW'(req.step_total);

   always_comb begin
      logic advance;
      logic active;
      clock_ms_in = clock_ms_ff;
      clock_nx_in = clock_nx_ff;
      steps_in    = steps_ff;
      cur_in      = cur_ff;
      tone_on_in  = tone_on_ff;
      in_gap_in   = in_gap_ff;
      step_dl_in  = step_dl_ff;
      rem_en_in   = rem_en_ff;
      rem_snd_in  = rem_snd_ff;
      rem_dl_in   = rem_dl_ff;
      rem_gap_in  = rem_gap_ff;
      bz_freq_in  = bz_freq_ff;
      bz_duty_in  = bz_duty_ff;
      tbl_wr.en   = 1'b0;
      tbl_wr.slot = req.step_slot[bts_pkg::STEP_IDX_W-1:0];
      tbl_wr.data = '{freq: req.step_freq_hz, on_ms: req.step_on_ms,
                      gap_ms: req.step_gap_ms};
      advance     = 1'b0;
      active      = 1'b0;

      case (req.mode)
         bts_pkg::MODE_TICK: begin
            clock_ms_in = clock_nx_ff;
            clock_nx_in = clock_nx_ff + 32'd1;
            // step sequencer
            if (steps_ff != '0) begin
               if (seq_start_tone) begin
                  bz_freq_in = cur_step.freq;
                  bz_duty_in = vol_duty;
                  tone_on_in = 1'b1;
                  step_dl_in = seq_sum;
               end else if (seq_due) begin
                  if (tone_on_ff) begin
                     tone_on_in = 1'b0;
                     if (cur_step.gap_ms != '0) begin
                        bz_duty_in = '0;
                        in_gap_in  = 1'b1;
                        step_dl_in = seq_sum;
                     end else begin
                        advance = 1'b1;
                     end
                  end else begin
                     in_gap_in = 1'b0;
                     advance   = 1'b1;
                  end
               end
            end
            if (advance) begin
               if (cur_inc >= steps_ff) begin
                  bz_duty_in = '0;
                  steps_in   = '0;
                  cur_in     = '0;
                  tone_on_in = 1'b0;
                  in_gap_in  = 1'b0;
                  step_dl_in = '0;
               end else begin
                  cur_in = cur_inc;
               end
            end
            // reminder beep, held off by an active sequence or zero volume
            active = (steps_in != '0) || tone_on_in || in_gap_in;
            if (!rem_en_ff || cfg.volume_level == '0 || active) begin
               if (rem_snd_ff) begin
                  bz_duty_in = '0;
                  rem_snd_in = 1'b0;
               end
            end else if (rem_due) begin
               if (!rem_snd_ff) begin
                  bz_freq_in = cfg.reminder_freq_hz;
                  bz_duty_in = vol_duty;
                  rem_snd_in = 1'b1;
               end else begin
                  bz_duty_in = '0;
                  rem_snd_in = 1'b0;
               end
               rem_dl_in = rem_sum;
            end
         end
         bts_pkg::MODE_LOAD_STEP: begin
            tbl_wr.en = 32'(req.step_slot) < bts_pkg::STEP_DEPTH;
         end
         bts_pkg::MODE_START_SEQ: begin
            if (cfg.volume_level == '0) begin
               bz_duty_in = '0;
               steps_in   = '0;
            end else begin
               steps_in = total_sat;
            end
            cur_in     = '0;
            tone_on_in = 1'b0;
            in_gap_in  = 1'b0;
            step_dl_in = '0;
         end
         bts_pkg::MODE_REM_START: begin
            rem_en_in  = 1'b1;
            rem_snd_in = 1'b0;
            rem_gap_in = cfg.reminder_period_ms;
            rem_dl_in  = clock_ms_ff + 32'(cfg.reminder_period_ms);
         end
         bts_pkg::MODE_REM_STOP: begin
            rem_en_in  = 1'b0;
            rem_snd_in = 1'b0;
            rem_dl_in  = '0;
            rem_gap_in = '0;
            if (steps_ff == '0 && !tone_on_ff && !in_gap_ff) begin
               bz_duty_in = '0;
            end
         end
         default: begin
         end
      endcase

      if (!go) begin
         tbl_wr.en = 1'b0;
      end

      result.tone_freq_hz   = bz_freq_in;
      result.tone_duty      = bz_duty_in;
      result.sequence_busy  = (steps_in != '0) || tone_on_in || in_gap_in;
      result.reminder_armed = rem_en_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clock_ms_ff <= '0;
         clock_nx_ff <= 32'd1;
         steps_ff    <= '0;
         cur_ff      <= '0;
         tone_on_ff  <= 1'b0;
         in_gap_ff   <= 1'b0;
         step_dl_ff  <= '0;
         rem_en_ff   <= 1'b0;
         rem_snd_ff  <= 1'b0;
         rem_dl_ff   <= '0;
         rem_gap_ff  <= '0;
         bz_freq_ff  <= '0;
         bz_duty_ff  <= '0;
      end else if (go) begin
         clock_ms_ff <= clock_ms_in;
         clock_nx_ff <= clock_nx_in;
         steps_ff    <= steps_in;
         cur_ff      <= cur_in;
         tone_on_ff  <= tone_on_in;
         in_gap_ff   <= in_gap_in;
         step_dl_ff  <= step_dl_in;
         rem_en_ff   <= rem_en_in;
         rem_snd_ff  <= rem_snd_in;
         rem_dl_ff   <= rem_dl_in;
         rem_gap_ff  <= rem_gap_in;
         bz_freq_ff  <= bz_freq_in;
         bz_duty_ff  <= bz_duty_in;
      end
   end

endmodule
